FILE: sv/psw_pkg.sv
// Shared widths, word types and constants for the point-to-edge window distance core.
package psw_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int NUM_W      = PROD_W + 2;
   localparam int DEN_W      = PROD_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int CMAG_W     = PROD_W;
   localparam int SQ_W       = 2 * CMAG_W;
   localparam int DIVD_W     = SQ_W + 2;
   localparam int QUO_W      = PROD_W + 2;
   localparam int WIN_W      = 7;
   localparam int CMP_W      = NUM_W + WIN_W + 2;
   localparam int DIST_W     = 36;
   localparam int CSR_IDX_W  = 1;

   localparam logic [DIST_W-1:0]    DIST_MAX  = '1;
   localparam logic [WIN_W-1:0]     LOW_RESET = WIN_W'(15);
   localparam logic [WIN_W-1:0]     HIGH_RESET = WIN_W'(85);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HIGH = CSR_IDX_W'(1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type head_x;
      coord_type head_y;
      coord_type head_z;
      coord_type tail_x;
      coord_type tail_y;
      coord_type tail_z;
   } req_word_type;

   typedef struct packed {
      logic              in_window;
      logic [DIST_W-1:0] sq_distance;
   } rsp_word_type;

   // Word handed from cell to cell in the divider chain.
   typedef struct packed {
      logic              valid;
      logic              in_win;
      logic [DEN_W-1:0]  den;
      logic [DEN_W-1:0]  rem;
      logic [QUO_W-1:0]  bits;
      logic [QUO_W-1:0]  quo;
   } cell_word_type;

endpackage

FILE: sv/psw_ifs.sv
// Valid/ready channel interfaces for request and response words.
interface psw_req_if;
   import psw_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface psw_rsp_if;
   import psw_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/psw_div_cell.sv
// One restoring-division cell: develops one quotient bit per word.
module psw_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  psw_pkg::cell_word_type  word_in,
   output psw_pkg::cell_word_type  word_out
);
   import psw_pkg::*;

   cell_word_type      word_ff;
   cell_word_type      word_in_next;
   logic [DEN_W:0]     trial;
   logic [DEN_W:0]     diff;

   // shift next dividend bit into the partial remainder and try subtract
   always_comb begin
      trial = {word_in.rem, word_in.bits[QUO_W-1]};
      diff  = trial - {1'b0, word_in.den};
      word_in_next = word_in;
      word_in_next.bits = {word_in.bits[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, word_in.den}) begin
         word_in_next.rem = diff[DEN_W-1:0];
         word_in_next.quo = {word_in.quo[QUO_W-2:0], 1'b1};
      end else begin
         word_in_next.rem = trial[DEN_W-1:0];
         word_in_next.quo = {word_in.quo[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in_next;
      end
      if (reset) begin
         word_ff.valid <= 1'b0;
      end
   end

   assign word_out = word_ff;
endmodule

FILE: sv/psw_geometry.sv
// Front pipeline: differences, products, dot and cross terms, window test.
module psw_geometry (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     word_valid,
   input  psw_pkg::req_word_type    word,
   input  logic [psw_pkg::WIN_W-1:0] window_low,
   input  logic [psw_pkg::WIN_W-1:0] window_high,
   output psw_pkg::cell_word_type   cell_out
);
   import psw_pkg::*;

   // stage 1: differences
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] ax_ff, ay_ff, az_ff, ex_ff, ey_ff, ez_ff;
   // stage 2: products
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] pdx_ff, pdy_ff, pdz_ff, pex_ff, pey_ff, pez_ff;
   logic signed [PROD_W-1:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   // stage 3: sums
   logic                     s3_valid_ff;
   logic signed [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [CMAG_W-1:0]        mx_ff, my_ff, mz_ff;
   // stage 4: scaled terms and squares
   logic                     s4_valid_ff;
   logic signed [CMP_W-1:0]  n100_ff, lo_ff, hi_ff;
   logic [DEN_W-1:0]         den4_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff, sqz_ff;
   // stage 5: window result and dividend
   cell_word_type            cell_ff;

   logic signed [CROSS_W-1:0] cx, cy, cz;
   logic [DIVD_W-1:0]         dividend;

   // cross components and the dividend (sum of the squared cross magnitudes)
   always_comb begin
      cx = CROSS_W'(c1_ff) - CROSS_W'(c2_ff);
      cy = CROSS_W'(c3_ff) - CROSS_W'(c4_ff);
      cz = CROSS_W'(c5_ff) - CROSS_W'(c6_ff);
      dividend = DIVD_W'(sqx_ff) + DIVD_W'(sqy_ff) + DIVD_W'(sqz_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_valid_ff <= word_valid;
         ax_ff <= DIFF_W'(word.point_x) - DIFF_W'(word.tail_x);
         ay_ff <= DIFF_W'(word.point_y) - DIFF_W'(word.tail_y);
         az_ff <= DIFF_W'(word.point_z) - DIFF_W'(word.tail_z);
         ex_ff <= DIFF_W'(word.head_x) - DIFF_W'(word.tail_x);
         ey_ff <= DIFF_W'(word.head_y) - DIFF_W'(word.tail_y);
         ez_ff <= DIFF_W'(word.head_z) - DIFF_W'(word.tail_z);

         s2_valid_ff <= s1_valid_ff;
         pdx_ff <= ax_ff * ex_ff;
         pdy_ff <= ay_ff * ey_ff;
         pdz_ff <= az_ff * ez_ff;
         pex_ff <= ex_ff * ex_ff;
         pey_ff <= ey_ff * ey_ff;
         pez_ff <= ez_ff * ez_ff;
         c1_ff  <= ay_ff * ez_ff;
         c2_ff  <= az_ff * ey_ff;
         c3_ff  <= az_ff * ex_ff;
         c4_ff  <= ax_ff * ez_ff;
         c5_ff  <= ax_ff * ey_ff;
         c6_ff  <= ay_ff * ex_ff;

         s3_valid_ff <= s2_valid_ff;
         num_ff <= NUM_W'(pdx_ff) + NUM_W'(pdy_ff) + NUM_W'(pdz_ff);
         den_ff <= DEN_W'(pex_ff) + DEN_W'(pey_ff) + DEN_W'(pez_ff);
         mx_ff  <= cx[CROSS_W-1] ? CMAG_W'(-cx) : CMAG_W'(cx);
         my_ff  <= cy[CROSS_W-1] ? CMAG_W'(-cy) : CMAG_W'(cy);
         mz_ff  <= cz[CROSS_W-1] ? CMAG_W'(-cz) : CMAG_W'(cz);

         s4_valid_ff <= s3_valid_ff;
         n100_ff <= CMP_W'(num_ff) * CMP_W'(100);
         lo_ff   <= $signed({2'b00, DEN_W'(0) | den_ff} * {{(CMP_W-WIN_W){1'b0}}, window_low});
         hi_ff   <= $signed({2'b00, DEN_W'(0) | den_ff} * {{(CMP_W-WIN_W){1'b0}}, window_high});
         den4_ff <= den_ff;
         sqx_ff  <= mx_ff * mx_ff;
         sqy_ff  <= my_ff * my_ff;
         sqz_ff  <= mz_ff * mz_ff;

         // exact window test by cross-multiplication; empty edge is outside
         cell_ff.valid  <= s4_valid_ff;
         cell_ff.in_win <= (den4_ff != '0) && (n100_ff >= lo_ff) && (n100_ff <= hi_ff);
         cell_ff.den    <= den4_ff;
         cell_ff.rem    <= dividend[DIVD_W-1:QUO_W];
         cell_ff.bits   <= dividend[QUO_W-1:0];
         cell_ff.quo    <= '0;
      end
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         cell_ff.valid <= 1'b0;
      end
   end

   assign cell_out = cell_ff;
endmodule

FILE: sv/point_segment_window_distance_core.sv
// Pipeline: 5 front stages, then one divider cell per quotient bit (36 cells), then the output register.
// Throughput: one word per cycle; the whole pipe advances together and stalls
// only when the output register holds a word that is not taken.
// The divider is a chain of restoring cells, one quotient bit each.
// Reset (synchronous, active high) empties the pipe and sets the window to 15..85.
// Top level: point-to-edge squared distance with projection window test.
module point_segment_window_distance_core (
   input  logic                               clock,
   input  logic                               reset,
   psw_req_if.sink                            req_word,
   psw_rsp_if.source                          rsp_word,
   input  logic                               csr_write_enable,
   input  logic [psw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psw_pkg::WIN_W-1:0]          csr_write_data
);
   import psw_pkg::*;

   logic              enable;
   logic [WIN_W-1:0]  win_low_ff, win_high_ff;
   cell_word_type     chain [QUO_W+1];
   logic              rsp_valid_ff;
   rsp_word_type      rsp_payload_ff;
   logic              over;

   assign enable         = !rsp_valid_ff || rsp_word.ready;
   assign req_word.ready = enable;

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_low_ff  <= LOW_RESET;
         win_high_ff <= HIGH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_LOW:  win_low_ff  <= csr_write_data;
            CSR_WINDOW_HIGH: win_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   psw_geometry u_geometry (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .word_valid  (req_word.valid),
      .word        (req_word.payload),
      .window_low  (win_low_ff),
      .window_high (win_high_ff),
      .cell_out    (chain[0])
   );

   // divider chain
   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      psw_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .word_in  (chain[i]),
         .word_out (chain[i+1])
      );
   end

   assign over = 64'(chain[QUO_W].quo) > 64'(DIST_MAX);

   // output register
   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_valid_ff <= chain[QUO_W].valid;
         rsp_payload_ff.in_window <= chain[QUO_W].in_win;
         if (!chain[QUO_W].in_win || over) begin
            rsp_payload_ff.sq_distance <= DIST_MAX;
         end else begin
            rsp_payload_ff.sq_distance <= DIST_W'(chain[QUO_W].quo);
         end
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_word.valid   = rsp_valid_ff;
   assign rsp_word.payload = rsp_payload_ff;
endmodule

FILE: sv/psw_checker.sv
// Port-level checker for the core, attached by bind.
module psw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_in_window,
   input logic [psw_pkg::DIST_W-1:0]   rsp_sq_distance
);
   import psw_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sq_distance)
                                  && $stable(rsp_in_window))
      else $error("response word changed while stalled");

   // out of window words saturate
   a_out_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_window |-> rsp_sq_distance == DIST_MAX)
      else $error("out of window word not saturated");

   // pipe empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled output stalls intake
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");
endmodule

bind point_segment_window_distance_core psw_checker u_psw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_word.valid),
   .req_ready       (req_word.ready),
   .rsp_valid       (rsp_word.valid),
   .rsp_ready       (rsp_word.ready),
   .rsp_in_window   (rsp_word.payload.in_window),
   .rsp_sq_distance (rsp_word.payload.sq_distance)
);
